FILE: hdl/ztsd_pkg.sv
package ztsd_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [KEY_W-1:0] KEY_A_INIT = 32'h1234_5678;
  localparam logic [KEY_W-1:0] KEY_B_INIT = 32'h2345_6789;
  localparam logic [KEY_W-1:0] KEY_C_INIT = 32'h3456_7890;
  localparam logic [KEY_W-1:0] LCG_MULT   = 32'd134775813;
  localparam logic [KEY_W-1:0] CRC_POLY   = 32'hEDB8_8320;

  // command codes
  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_ABSORB  = 2'd1;
  localparam logic [1:0] CMD_DECRYPT = 2'd2;

  // register indexes
  localparam logic REG_CHECK_VALUE = 1'b0;

  // step strobes from the sequencer to the key datapath
  typedef struct packed {
    logic load_init;
    logic ks_step;
    logic crca_step;
    logic mul_step;
    logic crcb_step;
    logic use_plain;
  } ctrl_t;

  // one finished result from the sequencer
  typedef struct packed {
    logic emit;
    logic done;
    logic match;
  } res_t;

  // one byte of crc-32, bit at a time
  function automatic logic [KEY_W-1:0] crc_step(input logic [KEY_W-1:0] crc,
                                               input logic [7:0] data);
    logic [KEY_W-1:0] r;
    r = {24'd0, crc[7:0] ^ data};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r ^ (crc >> 8);
  endfunction

endpackage

FILE: hdl/ztsd_stream_if.sv
interface ztsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface ztsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       header_done;
  logic       header_match;

  modport source (output valid, output plain_byte, output header_done,
                  output header_match, input ready);
  modport sink   (input valid, input plain_byte, input header_done,
                  input header_match, output ready);
endinterface

FILE: hdl/ztsd_keys.sv
module ztsd_keys (
  input  logic                clk,
  input  logic                rst,
  input  ztsd_pkg::ctrl_t     ctl,
  input  logic [7:0]          byte_q,
  output logic [7:0]          plain
);

  logic [ztsd_pkg::KEY_W-1:0]   key_a;
  logic [ztsd_pkg::KEY_W-1:0]   key_lcg;
  logic [ztsd_pkg::KEY_W-1:0]   key_b;
  logic [ztsd_pkg::KEY_W-1:0]   prod;
  logic [7:0]                   plain_q;

  logic [15:0]                  t;
  logic [ztsd_pkg::KEY_W-1:0]   mul_a;
  logic [ztsd_pkg::KEY_W-1:0]   mul_b;
  logic [2*ztsd_pkg::KEY_W-1:0] mul_full;
  logic [7:0]                   plain_now;
  logic [7:0]                   crca_in;
  logic [ztsd_pkg::KEY_W-1:0]   lcg_new;

  always_comb begin
    t         = key_b[15:0] | 16'h0002;
    plain_now = byte_q ^ prod[15:8];
    crca_in   = ctl.use_plain ? plain_now : byte_q;
    lcg_new   = prod + 32'd1;
    // shared multiplier: keystream product t * (t ^ 1) or lcg update
    if (ctl.mul_step) begin
      mul_a = key_lcg + {24'd0, key_a[7:0]};
      mul_b = ztsd_pkg::LCG_MULT;
    end else begin
      mul_a = {16'd0, t};
      mul_b = {16'd0, t ^ 16'h0001};
    end
    mul_full = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.load_init) begin
      key_a   <= ztsd_pkg::KEY_A_INIT;
      key_lcg <= ztsd_pkg::KEY_B_INIT;
      key_b   <= ztsd_pkg::KEY_C_INIT;
    end else begin
      if (ctl.crca_step) begin
        key_a <= ztsd_pkg::crc_step(key_a, crca_in);
      end
      if (ctl.crcb_step) begin
        key_lcg <= lcg_new;
        key_b   <= ztsd_pkg::crc_step(key_b, lcg_new[31:24]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ks_step || ctl.mul_step) begin
      prod <= mul_full[ztsd_pkg::KEY_W-1:0];
    end
    if (ctl.crca_step && ctl.use_plain) begin
      plain_q <= plain_now;
    end
  end

  assign plain = plain_q;

endmodule

FILE: hdl/ztsd_ctrl.sv
module ztsd_ctrl #(
  parameter int HEADER_BYTES = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_cmd,
  output logic             in_ready,
  input  logic             out_busy,
  input  logic [7:0]       plain,
  input  logic [7:0]       check_value,
  output ztsd_pkg::ctrl_t  ctl,
  output ztsd_pkg::res_t   res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KS   = 3'd1;
  localparam logic [2:0] ST_CRCA = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_CRCB = 3'd4;

  localparam logic [ztsd_pkg::COUNT_W-1:0] HB = ztsd_pkg::COUNT_W'(HEADER_BYTES);

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic                           dec;
  logic                           dec_next;
  logic [ztsd_pkg::COUNT_W-1:0]   count;
  logic [ztsd_pkg::COUNT_W-1:0]   count_next;
  logic [ztsd_pkg::COUNT_W-1:0]   count_inc;

  assign in_ready  = (state == ST_IDLE);
  assign count_inc = count + 1'b1;

  always_comb begin
    state_next = state;
    dec_next   = dec;
    count_next = count;
    ctl        = '0;
    res        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            ztsd_pkg::CMD_RESTART: begin
              ctl.load_init = 1'b1;
              count_next    = '0;
            end
            ztsd_pkg::CMD_ABSORB: begin
              dec_next   = 1'b0;
              state_next = ST_CRCA;
            end
            ztsd_pkg::CMD_DECRYPT: begin
              dec_next   = 1'b1;
              state_next = ST_KS;
            end
            default: begin
            end
          endcase
        end
      end
      ST_KS: begin
        ctl.ks_step = 1'b1;
        state_next  = ST_CRCA;
      end
      ST_CRCA: begin
        ctl.crca_step = 1'b1;
        ctl.use_plain = dec;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul_step = 1'b1;
        state_next   = ST_CRCB;
      end
      ST_CRCB: begin
        if (!(dec && out_busy)) begin
          ctl.crcb_step = 1'b1;
          state_next    = ST_IDLE;
          if (dec) begin
            res.emit = 1'b1;
            if (count < HB) begin
              count_next = count_inc;
              res.done   = (count_inc == HB);
              res.match  = (count_inc == HB) && (plain == check_value);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dec   <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      dec   <= dec_next;
      count <= count_next;
    end
  end

endmodule

FILE: hdl/zip_traditional_stream_decrypt_top.sv
// a decrypt passes states ks, crca, mul and crcb, then its result is registered;
// an absorb passes crca, mul and crcb to update the keys; a restart acts at once,
// one restart per cycle; a new decrypt or absorb is taken only back in idle, as the
// single shared multiplier and two crc steps work through the key update in turn
// reset (rst, synchronous): keys load their initial constants, header count and
// check_value clear, no result pending
module zip_traditional_stream_decrypt_top #(
  parameter int HEADER_BYTES = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  ztsd_in_if.sink                       in_ch,
  ztsd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ztsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ztsd_pkg::DATA_W-1:0]   pwdata,
  output logic [ztsd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  ztsd_pkg::ctrl_t ctl;
  ztsd_pkg::res_t  res;

  logic [7:0] check_value;
  logic [7:0] byte_q;
  logic [7:0] plain;
  logic       out_valid;
  logic [7:0] out_plain;
  logic       out_done;
  logic       out_match;
  logic       out_busy;
  logic       reg_idx;
  logic       in_xact;

  // apb register file: a single check byte, selected whenever paddr[2] is 0
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_comb begin
    prdata = '0;
    if (reg_idx == ztsd_pkg::REG_CHECK_VALUE) begin
      prdata = {24'd0, check_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_value <= '0;
    end else if (psel && penable && pwrite && pready
                 && reg_idx == ztsd_pkg::REG_CHECK_VALUE) begin
      check_value <= pwdata[7:0];
    end
  end

  // capture the byte of each accepted transaction for the key steps
  assign in_xact = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_xact) begin
      byte_q <= in_ch.data_byte;
    end
  end

  // the sequencer holds a decrypt in its last step while the output slot is still full
  assign out_busy = out_valid && !out_ch.ready;

  ztsd_ctrl #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_cmd      (in_ch.cmd),
    .in_ready    (in_ch.ready),
    .out_busy    (out_busy),
    .plain       (plain),
    .check_value (check_value),
    .ctl         (ctl),
    .res         (res)
  );

  ztsd_keys u_keys (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .byte_q (byte_q),
    .plain  (plain)
  );

  // output register: parts the result from the next accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_plain <= plain;
      out_done  <= res.done;
      out_match <= res.match;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.plain_byte   = out_plain;
  assign out_ch.header_done  = out_done;
  assign out_ch.header_match = out_match;

endmodule
